FILE: src/ars_pkg.sv
// Shared types, codes and constants of the aileron roll sequencer.
// No dependencies; used by the step logic, the top level and the checker.
package ars_pkg;

    // Parameter default
    localparam int ARS_MAX_TURNS = 5;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ENTRY = 2'd1;
    localparam logic [1:0] PH_ROLL  = 2'd2;
    localparam logic [1:0] PH_EXIT  = 2'd3;

    // Request actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Maneuver codes; only the aileron roll is accepted
    localparam logic [1:0] MAN_AILERON_ROLL = 2'd0;

    // Start status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_BAD_MAN   = 3'd2;
    localparam logic [2:0] ST_NOT_FLY   = 3'd3;
    localparam logic [2:0] ST_LOW       = 3'd4;
    localparam logic [2:0] ST_NO_ASPD   = 3'd5;
    localparam logic [2:0] ST_SLOW      = 3'd6;
    localparam logic [2:0] ST_NOT_LEVEL = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEF_RATE   = 2'd0;
    localparam logic [1:0] CFG_PITCH_TGT  = 2'd1;
    localparam logic [1:0] CFG_MIN_ALT    = 2'd2;
    localparam logic [1:0] CFG_MIN_ASPD   = 2'd3;

    // Configuration reset values
    localparam logic [15:0] CFG_DEF_RATE_RST  = 16'd18000;
    localparam logic [12:0] CFG_PITCH_TGT_RST = 13'd2500;
    localparam logic [10:0] CFG_MIN_ALT_RST   = 11'd500;
    localparam logic [13:0] CFG_MIN_ASPD_RST  = 14'd1000;

    // One full turn in accumulator units (0.01 deg/s times us)
    localparam longint ARS_TURN_UNITS = 64'sd36000000000;
    localparam int     ACC_W          = 48;
    localparam int     PROD_W         = 35;

    // Packed stream widths
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [15:0] def_rate;
        logic [12:0] pitch_tgt;
        logic [10:0] min_alt;
        logic [13:0] min_aspd;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        time_ms;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [18:0] gyro;
        logic [1:0]         maneuver;
        logic [2:0]         flags;
        logic [7:0]         reps;
        logic [15:0]        req_rate;
        logic signed [17:0] alt;
        logic [13:0]        aspd;
        logic signed [PROD_W-1:0] gyro_dt;
    } item_t;

    typedef struct packed {
        logic [1:0]              phase;
        logic [31:0]             start_ms;
        logic signed [ACC_W-1:0] acc;
        logic signed [16:0]      rate;
    } state_t;

    typedef struct packed {
        logic               active;
        logic signed [16:0] roll_cmd;
        logic signed [13:0] pitch_cmd;
        logic [2:0]         status;
        logic [1:0]         phase;
    } result_t;

endpackage

FILE: src/ars_step.sv
// One sequencer step: start checks, phase logic and the next state.
// Pure combinational; depends on ars_pkg.
module ars_step #(
    parameter int MAX_TURNS = ars_pkg::ARS_MAX_TURNS,
    parameter int THR_W     = 40
) (
    input  ars_pkg::cfg_t     cfg,
    input  ars_pkg::item_t    item,
    input  ars_pkg::state_t   cur,
    input  logic [THR_W-1:0]  thr_cur,
    output ars_pkg::state_t   nxt,
    output logic [THR_W-1:0]  thr_nxt,
    output ars_pkg::result_t  res
);
    import ars_pkg::*;

    localparam int TURN_W = $clog2(MAX_TURNS + 1);

    // Symmetric clamp of an 18-bit value.
    function automatic logic signed [17:0] clamp18(input logic signed [17:0] v,
                                                   input logic signed [17:0] lim);
        logic signed [17:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    // Leveling commands for entry and exit; the roll command is shared.
    logic signed [17:0] roll_lvl;
    logic signed [17:0] pitch_lvl;
    logic signed [17:0] pitch_dev;
    logic signed [17:0] pitch_entry;
    logic [31:0]        elapsed;

    assign roll_lvl    = clamp18(-(18'(item.roll) <<< 1), 18'sd9000);
    assign pitch_lvl   = clamp18(-(18'(item.pitch) <<< 1), 18'sd4500);
    assign pitch_dev   = $signed({5'd0, cfg.pitch_tgt}) - 18'(item.pitch);
    assign pitch_entry = clamp18(pitch_dev <<< 1, 18'sd4500);
    assign elapsed     = item.time_ms - cur.start_ms;

    // Rolling: saturating accumulate and full-turn test.
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic signed [ACC_W-1:0] thr_s;
    logic                    turns_done;

    assign acc_sum = (ACC_W+1)'(cur.acc) + (ACC_W+1)'(item.gyro_dt);
    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end
    assign thr_s      = $signed(ACC_W'(thr_cur));
    assign turns_done = (acc_sat >= thr_s) || (acc_sat <= -thr_s);

    // Start checks, in priority order.
    logic [17:0] aspd_x10;
    logic [17:0] min_x13;
    logic        not_level;
    logic [2:0]  start_status;

    assign aspd_x10  = 18'(item.aspd) * 18'd10;
    assign min_x13   = 18'(cfg.min_aspd) * 18'd13;
    assign not_level = (item.roll > 16'sd2000) || (item.roll < -16'sd2000)
                    || (item.pitch > 15'sd2000) || (item.pitch < -15'sd2000);

    always_comb begin
        if (cur.phase != PH_IDLE) begin
            start_status = ST_BUSY;
        end else if (item.maneuver != MAN_AILERON_ROLL) begin
            start_status = ST_BAD_MAN;
        end else if (!item.flags[0]) begin
            start_status = ST_NOT_FLY;
        end else if (item.alt < $signed({7'd0, cfg.min_alt})) begin
            start_status = ST_LOW;
        end else if (!item.flags[1]) begin
            start_status = ST_NO_ASPD;
        end else if (aspd_x10 < min_x13) begin
            start_status = ST_SLOW;
        end else if (not_level) begin
            start_status = ST_NOT_LEVEL;
        end else begin
            start_status = ST_OK;
        end
    end

    // Turn count and signed rate taken at a successful start.
    logic [TURN_W-1:0]  turns_start;
    logic [THR_W-1:0]   thr_start;
    logic [15:0]        rate_pick;
    logic [15:0]        rate_clamp;
    logic signed [16:0] rate_start;

    always_comb begin
        if (item.reps == 8'd0) begin
            turns_start = TURN_W'(1);
        end else if (item.reps > 8'(MAX_TURNS)) begin
            turns_start = TURN_W'(MAX_TURNS);
        end else begin
            turns_start = TURN_W'(item.reps);
        end
    end
    assign thr_start = THR_W'(turns_start) * THR_W'(ARS_TURN_UNITS);

    assign rate_pick = (item.req_rate == 16'd0) ? cfg.def_rate : item.req_rate;
    always_comb begin
        if (rate_pick < 16'd3000) begin
            rate_clamp = 16'd3000;
        end else if (rate_pick > 16'd36000) begin
            rate_clamp = 16'd36000;
        end else begin
            rate_clamp = rate_pick;
        end
    end
    assign rate_start = item.flags[2] ? -$signed({1'b0, rate_clamp})
                                      : $signed({1'b0, rate_clamp});

    // Phase sequencing.
    always_comb begin
        nxt           = cur;
        thr_nxt       = thr_cur;
        res.active    = 1'b0;
        res.roll_cmd  = '0;
        res.pitch_cmd = '0;
        res.status    = ST_OK;
        case (item.action)
            ACT_START: begin
                res.status = start_status;
                if (start_status == ST_OK) begin
                    thr_nxt      = thr_start;
                    nxt.rate     = rate_start;
                    nxt.acc      = '0;
                    nxt.phase    = PH_ENTRY;
                    nxt.start_ms = item.time_ms;
                end
            end
            ACT_RESET: begin
                nxt.acc = '0;
                if (cur.phase != PH_IDLE) begin
                    nxt.phase    = PH_IDLE;
                    nxt.start_ms = item.time_ms;
                end
            end
            ACT_TICK: begin
                unique case (cur.phase)
                    PH_IDLE: begin
                        res.active = 1'b0;
                    end
                    PH_ENTRY: begin
                        res.active    = 1'b1;
                        res.roll_cmd  = 17'(roll_lvl);
                        res.pitch_cmd = 14'(pitch_entry);
                        if ((pitch_dev <= 18'sd300 && pitch_dev >= -18'sd300)
                            || elapsed >= 32'd3000) begin
                            nxt.acc      = '0;
                            nxt.phase    = PH_ROLL;
                            nxt.start_ms = item.time_ms;
                        end
                    end
                    PH_ROLL: begin
                        res.active   = 1'b1;
                        nxt.acc      = acc_sat;
                        res.roll_cmd = cur.rate;
                        if (turns_done) begin
                            res.roll_cmd = '0;
                            nxt.phase    = PH_EXIT;
                            nxt.start_ms = item.time_ms;
                        end
                    end
                    PH_EXIT: begin
                        res.active    = 1'b1;
                        res.roll_cmd  = 17'(roll_lvl);
                        res.pitch_cmd = 14'(pitch_lvl);
                        if ((item.roll <= 16'sd500 && item.roll >= -16'sd500
                             && item.pitch <= 15'sd500 && item.pitch >= -15'sd500
                             && item.gyro <= 19'sd2000 && item.gyro >= -19'sd2000)
                            || elapsed >= 32'd2000) begin
                            res.active    = 1'b0;
                            res.roll_cmd  = '0;
                            res.pitch_cmd = '0;
                            nxt.phase     = PH_IDLE;
                            nxt.start_ms  = item.time_ms;
                        end
                    end
                    default: begin
                        res.active = 1'b0;
                    end
                endcase
            end
            default: begin
                res.active = 1'b0;
            end
        endcase
        res.phase = nxt.phase;
    end

endmodule

FILE: src/aileron_roll_sequencer_core.sv
// Top level of the aileron roll sequencer: stream ports, registers, config.
// Depends on ars_pkg and ars_step.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the action (tick,
//   start, reset) and s_tdata the sensor and command fields. Each request
//   yields exactly one result on the m_ stream: m_tuser is the active flag,
//   m_tdata holds the rate commands, the start status and the new phase.
//   Configuration registers are written through cfg_valid/cfg_index/
//   cfg_data; cfg_ready is always high. Write them only while idle.
//   A request is captured in the input register together with its
//   gyro-times-dt product, then the step logic updates the state and
//   loads the result register. Throughput is one request per cycle while
//   the receiver does not stall; the state update of one request is
//   already visible to the next one.
//   If the receiver stalls, the result register holds and one more request
//   waits in the input register; s_tready then drops until m_tready returns.
//   Synchronous reset returns the phase to idle, clears the accumulator and
//   the start time, loads the register defaults and empties both stages.
module aileron_roll_sequencer_core #(
    parameter int MAX_TURNS = ars_pkg::ARS_MAX_TURNS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: time_ms, dt_us, roll_angle, pitch_angle,
    // gyro_roll_rate, maneuver, flags, repetitions, requested_rate,
    // altitude_agl, airspeed, zero pad
    input  logic [ars_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: action
    input  logic [1:0]                      s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: roll_rate_cmd, pitch_rate_cmd, start_status,
    // phase, zero pad
    output logic [ars_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: active
    output logic                            m_tuser,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);
    import ars_pkg::*;

    localparam longint THR_MAX = longint'(MAX_TURNS) * ARS_TURN_UNITS;
    localparam int     THR_W   = $clog2(THR_MAX + 1);

    // Configuration registers.
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.def_rate  <= CFG_DEF_RATE_RST;
            cfg_reg.pitch_tgt <= CFG_PITCH_TGT_RST;
            cfg_reg.min_alt   <= CFG_MIN_ALT_RST;
            cfg_reg.min_aspd  <= CFG_MIN_ASPD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEF_RATE:  cfg_reg.def_rate  <= cfg_data;
                CFG_PITCH_TGT: cfg_reg.pitch_tgt <= cfg_data[12:0];
                CFG_MIN_ALT:   cfg_reg.min_alt   <= cfg_data[10:0];
                CFG_MIN_ASPD:  cfg_reg.min_aspd  <= cfg_data[13:0];
                default:       cfg_reg.def_rate  <= cfg_reg.def_rate;
            endcase
        end
    end

    // Unpack the request and form the gyro-times-dt product.
    item_t              item_next;
    logic [15:0]        dt_us;
    logic signed [18:0] gyro_in;

    assign dt_us   = s_tdata[47:32];
    assign gyro_in = $signed(s_tdata[97:79]);

    always_comb begin
        item_next.action   = s_tuser;
        item_next.time_ms  = s_tdata[31:0];
        item_next.roll     = $signed(s_tdata[63:48]);
        item_next.pitch    = $signed(s_tdata[78:64]);
        item_next.gyro     = gyro_in;
        item_next.maneuver = s_tdata[99:98];
        item_next.flags    = s_tdata[102:100];
        item_next.reps     = s_tdata[110:103];
        item_next.req_rate = s_tdata[126:111];
        item_next.alt      = $signed(s_tdata[144:127]);
        item_next.aspd     = s_tdata[158:145];
        item_next.gyro_dt  = PROD_W'(gyro_in) * $signed(PROD_W'({1'b0, dt_us}));
    end

    // Input and result stage handshake.
    logic  in_valid_reg;
    item_t item_reg;
    logic  out_valid_reg;
    logic  step_fire;

    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

    // Sequencer state.
    state_t           state_reg;
    state_t           state_next;
    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_next;
    result_t          res_next;
    result_t          res_reg;

    ars_step #(
        .MAX_TURNS (MAX_TURNS),
        .THR_W     (THR_W)
    ) u_step (
        .cfg     (cfg_reg),
        .item    (item_reg),
        .cur     (state_reg),
        .thr_cur (thr_reg),
        .nxt     (state_next),
        .thr_nxt (thr_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase    <= PH_IDLE;
            state_reg.start_ms <= '0;
            state_reg.acc      <= '0;
            state_reg.rate     <= '0;
            thr_reg            <= THR_W'(ARS_TURN_UNITS);
        end else if (step_fire) begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.active;
    assign m_tdata  = {4'd0, res_reg.phase, res_reg.status,
                       res_reg.pitch_cmd, res_reg.roll_cmd};

endmodule

FILE: src/ars_checker.sv
// Port-level checks on the sequencer result stream, bound to the top level.
// Depends on ars_pkg and aileron_roll_sequencer_core.
module ars_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ars_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import ars_pkg::*;

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Commands are zero whenever the result is not active.
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[30:0] == 31'd0)
        else $error("nonzero command while inactive");

    // A nonzero start status comes only from a start, which is never active.
    a_status_inactive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:31] != ST_OK |-> !m_tuser)
        else $error("active result with start status");

    // Active results never report the idle phase.
    a_active_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[35:34] != PH_IDLE)
        else $error("active result in idle phase");

endmodule

bind aileron_roll_sequencer_core ars_checker u_ars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: test/testbench.sv
// Self-checking testbench for aileron_roll_sequencer_core: a built-in predictor
// follows every accepted request and checks each result against it.
// Depends on ars_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
    import ars_pkg::*;

    // Limits of the roll sequence arithmetic
    localparam int     RATE_MIN        = 3000;
    localparam int     RATE_MAX        = 36000;
    localparam int     PITCH_CMD_LIM   = 4500;
    localparam int     ROLL_CMD_LIM    = 9000;
    localparam int     ENTRY_BAND      = 300;
    localparam int     LEVEL_BAND      = 500;
    localparam int     LEVEL_GYRO      = 2000;
    localparam int     START_LEVEL     = 2000;
    localparam int     ENTRY_TIMEOUT   = 3000;
    localparam int     EXIT_TIMEOUT    = 2000;
    localparam longint ACC_TOP         = 64'sd140737488355327;
    localparam longint ACC_BOTTOM      = -ACC_TOP - 1;

    // Run control
    localparam int     DRAIN_CYCLES    = 4;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     RANDOM_ITEMS    = 1400;
    localparam int     CONFIG_EVERY    = 100;

    typedef struct {
        logic [1:0]         action;
        logic [31:0]        time_ms;
        logic [15:0]        dt;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [18:0] gyro;
        logic [1:0]         maneuver;
        logic [2:0]         flags;
        logic [7:0]         reps;
        logic [15:0]        req_rate;
        logic signed [17:0] alt;
        logic [13:0]        aspd;
    } roll_req_t;

    // Predicts the sequencer's answer to each request and checks the results.
    class roll_scoreboard;
        int         cfg_def_rate;
        int         cfg_pitch_tgt;
        int         cfg_min_alt;
        int         cfg_min_aspd;
        logic [1:0] phase;
        logic [31:0] phase_start;
        longint     acc;
        int         turns;
        longint     turn_rate;
        result_t    expected_results[$];
        int         errors;

        function new();
            cfg_def_rate  = CFG_DEF_RATE_RST;
            cfg_pitch_tgt = CFG_PITCH_TGT_RST;
            cfg_min_alt   = CFG_MIN_ALT_RST;
            cfg_min_aspd  = CFG_MIN_ASPD_RST;
            phase         = PH_IDLE;
            phase_start   = '0;
            acc           = 0;
            turns         = 1;
            turn_rate     = 0;
            errors        = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] value);
            case (index)
                CFG_DEF_RATE:  cfg_def_rate  = value;
                CFG_PITCH_TGT: cfg_pitch_tgt = value[12:0];
                CFG_MIN_ALT:   cfg_min_alt   = value[10:0];
                CFG_MIN_ASPD:  cfg_min_aspd  = value[13:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // The start time only moves when the phase really changes.
        function void move_to(logic [1:0] next_phase, logic [31:0] now);
            if (next_phase != phase) begin
                phase       = next_phase;
                phase_start = now;
            end
        endfunction

        function void note_request(roll_req_t r);
            result_t     want;
            longint      err;
            longint      rcmd;
            longint      pcmd;
            longint      rate_v;
            int          reps_v;
            logic [31:0] elapsed;
            bit          level;
            want    = '0;
            rcmd    = 0;
            pcmd    = 0;
            elapsed = r.time_ms - phase_start;
            case (r.action)
                ACT_START: begin
                    // Envelope checks in priority order; the first failure wins.
                    if (phase != PH_IDLE) want.status = ST_BUSY;
                    else if (r.maneuver != MAN_AILERON_ROLL) want.status = ST_BAD_MAN;
                    else if (!r.flags[0]) want.status = ST_NOT_FLY;
                    else if (longint'(r.alt) < longint'(cfg_min_alt)) want.status = ST_LOW;
                    else if (!r.flags[1]) want.status = ST_NO_ASPD;
                    else if (longint'(r.aspd) * 10 < longint'(cfg_min_aspd) * 13)
                        want.status = ST_SLOW;
                    else if (mag(longint'(r.roll)) > START_LEVEL ||
                             mag(longint'(r.pitch)) > START_LEVEL)
                        want.status = ST_NOT_LEVEL;
                    else begin
                        want.status = ST_OK;
                        reps_v = r.reps;
                        if (reps_v == 0) reps_v = 1;
                        if (reps_v > ARS_MAX_TURNS) reps_v = ARS_MAX_TURNS;
                        turns  = reps_v;
                        rate_v = r.req_rate;
                        if (rate_v == 0) rate_v = cfg_def_rate;
                        rate_v    = clamp(rate_v, RATE_MIN, RATE_MAX);
                        turn_rate = r.flags[2] ? -rate_v : rate_v;
                        acc       = 0;
                        move_to(PH_ENTRY, r.time_ms);
                    end
                end
                ACT_RESET: begin
                    acc = 0;
                    move_to(PH_IDLE, r.time_ms);
                end
                ACT_TICK: begin
                    if (phase == PH_ENTRY) begin
                        want.active = 1'b1;
                        err  = longint'(cfg_pitch_tgt) - longint'(r.pitch);
                        pcmd = clamp(2 * err, -PITCH_CMD_LIM, PITCH_CMD_LIM);
                        rcmd = clamp(-2 * longint'(r.roll), -ROLL_CMD_LIM, ROLL_CMD_LIM);
                        if (mag(err) <= ENTRY_BAND || elapsed >= ENTRY_TIMEOUT) begin
                            acc = 0;
                            move_to(PH_ROLL, r.time_ms);
                        end
                    end else if (phase == PH_ROLL) begin
                        // Integrate gyro times dt with saturation, stop at the turn count.
                        want.active = 1'b1;
                        acc  = clamp(acc + longint'(r.gyro) * longint'(r.dt),
                                     ACC_BOTTOM, ACC_TOP);
                        rcmd = turn_rate;
                        if (mag(acc) >= longint'(turns) * ARS_TURN_UNITS) begin
                            rcmd = 0;
                            move_to(PH_EXIT, r.time_ms);
                        end
                    end else if (phase == PH_EXIT) begin
                        want.active = 1'b1;
                        rcmd  = clamp(-2 * longint'(r.roll), -ROLL_CMD_LIM, ROLL_CMD_LIM);
                        pcmd  = clamp(-2 * longint'(r.pitch), -PITCH_CMD_LIM, PITCH_CMD_LIM);
                        level = mag(longint'(r.roll)) <= LEVEL_BAND &&
                                mag(longint'(r.pitch)) <= LEVEL_BAND &&
                                mag(longint'(r.gyro)) <= LEVEL_GYRO;
                        if (level || elapsed >= EXIT_TIMEOUT) begin
                            move_to(PH_IDLE, r.time_ms);
                            want.active = 1'b0;
                            rcmd = 0;
                            pcmd = 0;
                        end
                    end
                end
                default: ;
            endcase
            want.roll_cmd  = rcmd[16:0];
            want.pitch_cmd = pcmd[13:0];
            want.phase     = phase;
            expected_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got.active !== want.active)
                report_mismatch($sformatf("active got %0d expected %0d",
                                          got.active, want.active));
            if (got.roll_cmd !== want.roll_cmd)
                report_mismatch($sformatf("roll_rate_cmd got %0d expected %0d",
                                          got.roll_cmd, want.roll_cmd));
            if (got.pitch_cmd !== want.pitch_cmd)
                report_mismatch($sformatf("pitch_rate_cmd got %0d expected %0d",
                                          got.pitch_cmd, want.pitch_cmd));
            if (got.status !== want.status)
                report_mismatch($sformatf("start_status got %0d expected %0d",
                                          got.status, want.status));
            if (got.phase !== want.phase)
                report_mismatch($sformatf("phase got %0d expected %0d",
                                          got.phase, want.phase));
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = ACT_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = CFG_DEF_RATE;
    logic [15:0]           cfg_data  = '0;

    roll_scoreboard sb = new();
    int          src_idle_pct   = 28;
    int          sink_stall_pct = 84;
    int          idle_cycles    = 0;
    logic [31:0] flight_ms;

    aileron_roll_sequencer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // The receiver stalls at random.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Unpack every accepted result and check it.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.active    = m_tuser;
            got.roll_cmd  = m_tdata[16:0];
            got.pitch_cmd = m_tdata[30:17];
            got.status    = m_tdata[33:31];
            got.phase     = m_tdata[35:34];
            sb.check_result(got);
        end
    end

    // Watchdog: too long without any accepted request, result or register write.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // A benign request: level, flying, well inside the envelope.
    function automatic roll_req_t level_request(logic [1:0] action);
        roll_req_t r;
        flight_ms += 10;
        r.action   = action;
        r.time_ms  = flight_ms;
        r.dt       = 16'd1000;
        r.roll     = '0;
        r.pitch    = '0;
        r.gyro     = '0;
        r.maneuver = MAN_AILERON_ROLL;
        r.flags    = 3'b011;
        r.reps     = 8'd1;
        r.req_rate = '0;
        r.alt      = 18'sd1000;
        r.aspd     = 14'd5000;
        return r;
    endfunction

    // Random request shaped by the predicted phase, so most traffic runs whole
    // roll sequences and the rest is noise.
    function automatic roll_req_t random_request();
        roll_req_t r;
        int        pick;
        int        need;
        int        sign;
        if ($urandom_range(24) == 0) flight_ms += pick_between(1500, 3500);
        else flight_ms += $urandom_range(50);
        r.action   = ACT_TICK;
        r.time_ms  = flight_ms;
        r.dt       = 16'($urandom_range(65535));
        r.roll     = 16'(pick_between(-18000, 18000));
        r.pitch    = 15'(pick_between(-9000, 9000));
        r.gyro     = 19'(pick_between(-200000, 200000));
        r.maneuver = 2'($urandom_range(3));
        r.flags    = 3'($urandom_range(7));
        r.reps     = 8'($urandom_range(255));
        r.req_rate = 16'($urandom_range(65535));
        r.alt      = 18'(pick_between(-10000, 100000));
        r.aspd     = 14'($urandom_range(10000));
        pick = $urandom_range(99);
        if (sb.phase == PH_IDLE) begin
            if (pick < 55) begin
                // Start that passes the envelope, now and then just outside level.
                r.action   = ACT_START;
                r.maneuver = MAN_AILERON_ROLL;
                r.flags    = {1'($urandom_range(1)), 2'b11};
                r.alt      = 18'(pick_between(sb.cfg_min_alt, 100000));
                need       = (13 * sb.cfg_min_aspd + 9) / 10;
                if (need <= 10000) r.aspd = 14'(pick_between(need, 10000));
                if ($urandom_range(7) == 0) begin
                    r.roll  = 16'(pick_between(-2600, 2600));
                    r.pitch = 15'(pick_between(-2600, 2600));
                end else begin
                    r.roll  = 16'(pick_between(-START_LEVEL, START_LEVEL));
                    r.pitch = 15'(pick_between(-START_LEVEL, START_LEVEL));
                end
                if ($urandom_range(9) != 0) r.reps = 8'($urandom_range(3));
                if ($urandom_range(3) == 0) r.req_rate = '0;
            end else if (pick < 75) r.action = ACT_START;
            else if (pick < 85) r.action = ACT_TICK;
            else if (pick < 92) r.action = ACT_RESET;
            else r.action = ACT_NONE;
        end else if (pick < 82) begin
            // Tick with sensor data that lets the current phase make progress.
            if (sb.phase == PH_ENTRY && $urandom_range(1) == 0) begin
                r.pitch = 15'(sb.cfg_pitch_tgt + pick_between(-600, 600));
            end else if (sb.phase == PH_ROLL) begin
                sign   = (sb.turn_rate < 0) ? -1 : 1;
                if ($urandom_range(9) == 0) sign = -sign;
                r.gyro = 19'(sign * pick_between(60000, 200000));
                r.dt   = 16'(pick_between(30000, 65535));
            end else if (sb.phase == PH_EXIT && $urandom_range(99) < 35) begin
                r.roll  = 16'(pick_between(-LEVEL_BAND, LEVEL_BAND));
                r.pitch = 15'(pick_between(-LEVEL_BAND, LEVEL_BAND));
                r.gyro  = 19'(pick_between(-LEVEL_GYRO, LEVEL_GYRO));
            end
        end else if (pick < 88) r.action = ACT_START;
        else if (pick < 91) r.action = ACT_RESET;
        else if (pick < 94) r.action = ACT_NONE;
        return r;
    endfunction

    // Offer one request and wait until it is taken.
    task automatic send_request(input roll_req_t r);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.action;
        s_tdata  <= {1'b0, r.aspd, r.alt, r.req_rate, r.reps, r.flags, r.maneuver,
                     r.gyro, r.pitch, r.roll, r.dt, r.time_ms};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [15:0] def_rate, input logic [15:0] pitch_tgt,
                              input logic [15:0] min_alt, input logic [15:0] min_aspd);
        logic [1:0]  regs[4];
        logic [15:0] vals[4];
        regs = '{CFG_DEF_RATE, CFG_PITCH_TGT, CFG_MIN_ALT, CFG_MIN_ASPD};
        vals = '{def_rate, pitch_tgt, min_alt, min_aspd};
        for (int k = 0; k < 4; k++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(regs[k], vals[k]);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Bring the sequencer to idle, let it drain, then load a new setting.
    task automatic reconfigure(input int slot);
        if (sb.phase != PH_IDLE) send_request(level_request(ACT_RESET));
        drain();
        case (slot % 7)
            0: write_regs(16'd3000, 16'd0, 16'd200, 16'd0);
            1: write_regs(16'd36000, 16'd4500, 16'd2000, 16'd10000);
            default: write_regs(16'(pick_between(3000, 36000)), 16'(pick_between(0, 4500)),
                                16'(pick_between(200, 2000)), 16'(pick_between(0, 6000)));
        endcase
    endtask

    initial begin
        roll_req_t d;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset register values; time wraps during entry.
        flight_ms = 32'hFFFF_FF00;
        send_request(level_request(ACT_TICK));
        d = level_request(ACT_NONE);
        d.time_ms = '1; d.dt = '1; d.roll = 16'sd18000; d.pitch = 15'sd9000;
        d.gyro = 19'sd200000;
        d.maneuver = 2'd3; d.flags = 3'b111; d.reps = '1; d.req_rate = '1;
        d.alt = 18'sd100000; d.aspd = 14'd10000;
        send_request(d);
        d = level_request(ACT_RESET);
        d.time_ms = '0; d.dt = '0; d.roll = -16'sd18000; d.pitch = -15'sd9000;
        d.gyro = -19'sd200000;
        d.flags = 3'b000; d.reps = '0; d.alt = -18'sd10000; d.aspd = '0;
        send_request(d);
        d = level_request(ACT_START); d.maneuver = 2'd2; send_request(d);
        d = level_request(ACT_START); d.flags = 3'b110; send_request(d);
        d = level_request(ACT_START); d.alt = 18'sd499; send_request(d);
        d = level_request(ACT_START); d.alt = 18'sd500; d.flags = 3'b101; send_request(d);
        d = level_request(ACT_START); d.aspd = 14'd1299; send_request(d);
        d = level_request(ACT_START); d.aspd = 14'd1300; d.roll = 16'sd2001;
        send_request(d);
        d = level_request(ACT_START); d.pitch = -15'sd2001; send_request(d);
        d = level_request(ACT_START); d.roll = 16'sd2000; d.pitch = -15'sd2000;
        d.reps = '0;
        send_request(d);
        send_request(level_request(ACT_START));
        d = level_request(ACT_TICK); d.pitch = -15'sd9000; d.roll = 16'sd18000;
        send_request(d);
        // Entry timeout across the wrap of the millisecond clock.
        flight_ms += ENTRY_TIMEOUT;
        d = level_request(ACT_TICK); d.roll = -16'sd18000; send_request(d);
        repeat (3) begin
            d = level_request(ACT_TICK); d.gyro = 19'sd200000; d.dt = '1; send_request(d);
        end
        d = level_request(ACT_TICK); d.roll = 16'sd18000; d.pitch = 15'sd9000;
        d.gyro = 19'sd5000;
        send_request(d);
        d = level_request(ACT_TICK); d.roll = 16'sd500; d.pitch = -15'sd500;
        d.gyro = -19'sd2000;
        send_request(d);
        // Left roll with turns and rate clamped from above.
        d = level_request(ACT_START); d.flags = 3'b111; d.reps = 8'd255; d.req_rate = '1;
        send_request(d);
        d = level_request(ACT_TICK); d.pitch = 15'(CFG_PITCH_TGT_RST - ENTRY_BAND);
        send_request(d);
        d = level_request(ACT_TICK); d.gyro = -19'sd200000; d.dt = '1; send_request(d);
        send_request(level_request(ACT_RESET));
        // Rate clamped from below, entry ending at the upper edge of the band.
        d = level_request(ACT_START); d.reps = 8'd3; d.req_rate = 16'd1; send_request(d);
        d = level_request(ACT_TICK); d.pitch = 15'(CFG_PITCH_TGT_RST + ENTRY_BAND);
        send_request(d);
        send_request(level_request(ACT_TICK));

        // Random part in three idling regimes, with new settings now and then.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                src_idle_pct   = 84;
                sink_stall_pct = 28;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            if (i % CONFIG_EVERY == 0) reconfigure(i / CONFIG_EVERY);
            send_request(random_request());
        end
        drain();

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/ars_pkg.sv
src/ars_step.sv
src/aileron_roll_sequencer_core.sv
src/ars_checker.sv
test/testbench.sv
